// ----- sv/rfrt_pkg.sv -----
// ----------------------------------------------------------------------------
// RTP H.264 frame reassembly tracker package
// Shared types and constants of the frame reassembly tracker.
// ----------------------------------------------------------------------------
package rfrt_pkg;

    localparam int Depth = 32;
    localparam int SlotW = $clog2(Depth);
    localparam int CntW = $clog2(Depth + 1);
    localparam int MaxFrames = 32;

    localparam logic [4:0] NtStapa = 5'd24;
    localparam logic [4:0] NtFua = 5'd28;
    localparam logic [4:0] NtIdr = 5'd5;
    localparam logic [4:0] NtSps = 5'd7;
    localparam logic [4:0] NtPps = 5'd8;

    localparam int FlMark = 0;
    localparam int FlFus = 1;
    localparam int FlFue = 2;
    localparam int FlFua = 3;
    localparam int FlKey = 4;

    typedef enum logic [1:0] {
        KIND_FRAME = 2'd0,
        KIND_DONE = 2'd1,
        KIND_OVERFLOW = 2'd2
    } kind_t;

endpackage

// ----- sv/rtp_h264_frame_reassembly_tracker.sv -----
// ----------------------------------------------------------------------------
// RTP H.264 frame reassembly tracker
// Tracks packet headers in a ring and reports completed frame ranges.
// ----------------------------------------------------------------------------
// One packet is taken per start while busy is low. A packet that triggers no
// scan passes through the write and final states, and its single result is
// registered in the final state. A scan walks the ring one entry per cycle
// through a single compare unit, and each frame it finds is walked twice more,
// once to count FU-A bits and once to free it. Results appear for one cycle
// each with valid high and cannot be stalled; the final result of a packet has
// last set.
module rtp_h264_frame_reassembly_tracker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] seq_num,
    input  logic [31:0] rtp_time,
    input  logic        marker,
    input  logic [4:0]  nal_type,
    input  logic [4:0]  inner_nal_type,
    input  logic        fu_start,
    input  logic        fu_end,
    output logic        valid,
    output logic [1:0]  kind,
    output logic [15:0] frame_start_sn,
    output logic [15:0] frame_end_sn,
    output logic        key_frame,
    output logic        pli_request,
    output logic        last
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRITE,
        ST_REF,
        ST_SCAN,
        ST_CHECK,
        ST_COUNT,
        ST_FREE,
        ST_EMIT,
        ST_FINAL
    } state_t;

    localparam int SW = rfrt_pkg::SlotW;
    localparam int CW = rfrt_pkg::CntW;

    logic [31:0] mem_time [rfrt_pkg::Depth];
    logic [4:0]  mem_flags [rfrt_pkg::Depth];
    logic [rfrt_pkg::Depth-1:0] valid_reg;

    state_t      state_reg;
    logic [31:0] key_time_reg;
    logic        key_none_reg;
    logic [15:0] head_sn_reg;
    logic [15:0] missing_sn_reg;
    logic        key_seen_reg;

    logic [15:0] seq_reg;
    logic [31:0] ts_reg;
    logic [4:0]  fl_reg;
    logic        pli_reg;
    logic [31:0] ref_reg;
    logic [15:0] ptr_reg;
    logic [CW-1:0] cnt_reg;
    logic [15:0] found_reg;
    logic [6:0]  sc_reg;
    logic [6:0]  ec_reg;
    logic [5:0]  nframes_reg;
    logic        first_key_reg;

    logic        out_valid_reg;
    logic [1:0]  kind_reg;
    logic [15:0] fs_reg;
    logic [15:0] fe_reg;
    logic        kf_reg;
    logic        last_reg;

    logic        is_key;
    logic [4:0]  fl_in;
    logic [SW-1:0] pslot;
    logic [31:0] rd_time;
    logic [4:0]  rd_flags;
    logic        rd_valid;
    logic [15:0] len_calc;

    always_comb
    begin
        if (nal_type == rfrt_pkg::NtStapa)
        begin
            is_key = (inner_nal_type == rfrt_pkg::NtSps) ||
                     (inner_nal_type == rfrt_pkg::NtPps);
        end
        else
        begin
            is_key = (nal_type == rfrt_pkg::NtIdr) || (nal_type == rfrt_pkg::NtSps) ||
                     (nal_type == rfrt_pkg::NtPps);
        end
        fl_in = {is_key, (nal_type == rfrt_pkg::NtFua),
                 (nal_type == rfrt_pkg::NtFua) & fu_end,
                 (nal_type == rfrt_pkg::NtFua) & fu_start, marker};
    end

    assign pslot = ptr_reg[SW-1:0];
    assign rd_time = mem_time[pslot];
    assign rd_flags = mem_flags[pslot];
    assign rd_valid = valid_reg[pslot];
    assign len_calc = found_reg - head_sn_reg + 16'd1;

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_WRITE)
        begin
            mem_time[seq_reg[SW-1:0]] <= ts_reg;
            mem_flags[seq_reg[SW-1:0]] <= fl_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= '0;
            key_time_reg <= '0;
            key_none_reg <= 1'b1;
            head_sn_reg <= '0;
            missing_sn_reg <= '0;
            key_seen_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            kind_reg <= '0;
            fs_reg <= '0;
            fe_reg <= '0;
            kf_reg <= 1'b0;
            last_reg <= 1'b0;
            nframes_reg <= '0;
        end
        else
        begin
            out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        seq_reg <= seq_num;
                        ts_reg <= rtp_time;
                        fl_reg <= fl_in;
                        pli_reg <= ~key_seen_reg;
                        nframes_reg <= '0;
                        if (is_key)
                        begin
                            key_seen_reg <= 1'b1;
                            if (key_none_reg || key_time_reg != rtp_time)
                            begin
                                key_none_reg <= 1'b0;
                                key_time_reg <= rtp_time;
                                head_sn_reg <= seq_num;
                                missing_sn_reg <= seq_num + 16'd1;
                                valid_reg <= '0;
                            end
                        end
                        state_reg <= ST_WRITE;
                    end
                end
                ST_WRITE:
                begin
                    valid_reg[seq_reg[SW-1:0]] <= 1'b1;
                    if (fl_reg[rfrt_pkg::FlKey] && seq_reg[15:0] != head_sn_reg &&
                        ((seq_reg - head_sn_reg) & 16'h8000) != 16'd0)
                    begin
                        head_sn_reg <= seq_reg;
                        ptr_reg <= seq_reg;
                        state_reg <= ST_REF;
                    end
                    else if (missing_sn_reg == seq_reg)
                    begin
                        ptr_reg <= missing_sn_reg;
                        state_reg <= ST_REF;
                    end
                    else
                    begin
                        kind_reg <= rfrt_pkg::KIND_DONE;
                        state_reg <= ST_FINAL;
                    end
                end
                ST_REF:
                begin
                    ref_reg <= mem_time[head_sn_reg[SW-1:0]];
                    cnt_reg <= '0;
                    state_reg <= ST_SCAN;
                end
                ST_SCAN:
                begin
                    if (cnt_reg == CW'(rfrt_pkg::Depth))
                    begin
                        kind_reg <= rfrt_pkg::KIND_OVERFLOW;
                        state_reg <= ST_FINAL;
                    end
                    else if (!rd_valid)
                    begin
                        missing_sn_reg <= ptr_reg;
                        kind_reg <= rfrt_pkg::KIND_DONE;
                        state_reg <= ST_FINAL;
                    end
                    else if (rd_time != ref_reg)
                    begin
                        found_reg <= ptr_reg - 16'd1;
                        state_reg <= ST_CHECK;
                    end
                    else if (rd_flags[rfrt_pkg::FlMark])
                    begin
                        found_reg <= ptr_reg;
                        state_reg <= ST_CHECK;
                    end
                    else
                    begin
                        ptr_reg <= ptr_reg + 16'd1;
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                end
                ST_CHECK:
                begin
                    if (len_calc == 16'd0 || len_calc > 16'(rfrt_pkg::Depth))
                    begin
                        kind_reg <= rfrt_pkg::KIND_OVERFLOW;
                        state_reg <= ST_FINAL;
                    end
                    else
                    begin
                        ptr_reg <= head_sn_reg;
                        sc_reg <= '0;
                        ec_reg <= '0;
                        first_key_reg <= mem_flags[head_sn_reg[SW-1:0]][rfrt_pkg::FlKey];
                        state_reg <= ST_COUNT;
                    end
                end
                ST_COUNT:
                begin
                    if (rd_flags[rfrt_pkg::FlFua])
                    begin
                        sc_reg <= sc_reg + {6'd0, rd_flags[rfrt_pkg::FlFus]};
                        ec_reg <= ec_reg + {6'd0, rd_flags[rfrt_pkg::FlFue]};
                    end
                    if (ptr_reg == found_reg)
                    begin
                        state_reg <= ST_FREE;
                    end
                    else
                    begin
                        ptr_reg <= ptr_reg + 16'd1;
                    end
                end
                ST_FREE:
                begin
                    if (sc_reg != ec_reg || nframes_reg == 6'(rfrt_pkg::MaxFrames))
                    begin
                        kind_reg <= rfrt_pkg::KIND_DONE;
                        state_reg <= ST_FINAL;
                    end
                    else
                    begin
                        ptr_reg <= head_sn_reg;
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    valid_reg[pslot] <= 1'b0;
                    if (ptr_reg == found_reg)
                    begin
                        if (first_key_reg)
                        begin
                            key_none_reg <= 1'b1;
                        end
                        out_valid_reg <= 1'b1;
                        kind_reg <= rfrt_pkg::KIND_FRAME;
                        fs_reg <= head_sn_reg;
                        fe_reg <= found_reg;
                        kf_reg <= first_key_reg;
                        last_reg <= 1'b0;
                        nframes_reg <= nframes_reg + 6'd1;
                        head_sn_reg <= found_reg + 16'd1;
                        ptr_reg <= found_reg + 16'd1;
                        state_reg <= ST_REF;
                    end
                    else
                    begin
                        ptr_reg <= ptr_reg + 16'd1;
                    end
                end
                ST_FINAL:
                begin
                    out_valid_reg <= 1'b1;
                    fs_reg <= '0;
                    fe_reg <= '0;
                    kf_reg <= 1'b0;
                    last_reg <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign valid = out_valid_reg;
    assign kind = kind_reg;
    assign frame_start_sn = fs_reg;
    assign frame_end_sn = fe_reg;
    assign key_frame = kf_reg;
    assign pli_request = pli_reg;
    assign last = last_reg;

endmodule

// ----- sv/rfrt_checker.sv -----
// ----------------------------------------------------------------------------
// RTP H.264 frame reassembly tracker checker
// Port level checks of the tracker, bound to the top level.
// ----------------------------------------------------------------------------
module rfrt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        valid,
    input logic [1:0]  kind,
    input logic [15:0] frame_start_sn,
    input logic [15:0] frame_end_sn,
    input logic        key_frame,
    input logic        last
);

    // A final result is the only kind that ends a transfer sequence.
    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        valid && last |-> kind != rfrt_pkg::KIND_FRAME)
        else $error("final result carries a frame");

    a_frame_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid && kind == rfrt_pkg::KIND_FRAME |-> !last)
        else $error("frame result marked last");

    a_final_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid && last |-> frame_start_sn == 16'd0 && frame_end_sn == 16'd0 && !key_frame)
        else $error("final result has frame fields");

    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid && last |-> !busy)
        else $error("busy after final result");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted packet did not raise busy");

endmodule

bind rtp_h264_frame_reassembly_tracker rfrt_checker u_rfrt_checker (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .valid(valid),
    .kind(kind),
    .frame_start_sn(frame_start_sn),
    .frame_end_sn(frame_end_sn),
    .key_frame(key_frame),
    .last(last)
);

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// Frame reassembly tracker testbench
// Drives packet headers through the start/busy command interface and checks
// every strobed result against an in-bench predictor of the packet ring.
// ----------------------------------------------------------------------------
module tb;

    localparam int ScanGap = 0;
    localparam int ScanEnd = 1;
    localparam int ScanOvf = 2;

    typedef struct packed {
        logic [15:0] sn;
        logic [31:0] ts;
        logic        mark;
        logic [4:0]  nt;
        logic [4:0]  inner;
        logic        fus;
        logic        fue;
    } packet_t;

    typedef struct packed {
        rfrt_pkg::kind_t kind;
        logic [15:0] first_sn;
        logic [15:0] last_sn;
        logic        key;
        logic        pli;
        logic        fin;
    } report_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [15:0] seq_num;
    logic [31:0] rtp_time;
    logic        marker;
    logic [4:0]  nal_type;
    logic [4:0]  inner_nal_type;
    logic        fu_start;
    logic        fu_end;
    logic        valid;
    logic [1:0]  kind;
    logic [15:0] frame_start_sn;
    logic [15:0] frame_end_sn;
    logic        key_frame;
    logic        pli_request;
    logic        last;

    rtp_h264_frame_reassembly_tracker u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .seq_num(seq_num), .rtp_time(rtp_time), .marker(marker),
        .nal_type(nal_type), .inner_nal_type(inner_nal_type),
        .fu_start(fu_start), .fu_end(fu_end), .valid(valid), .kind(kind),
        .frame_start_sn(frame_start_sn), .frame_end_sn(frame_end_sn),
        .key_frame(key_frame), .pli_request(pli_request), .last(last)
    );

    packet_t packet_queue[$];
    report_t expected_reports[$];
    int      send_idle_pct;
    int      errors = 0;
    int      cycles = 0;
    logic    hold_sender;

    logic        ring_valid[rfrt_pkg::Depth];
    logic [31:0] ring_time[rfrt_pkg::Depth];
    logic [4:0]  ring_flags[rfrt_pkg::Depth];
    logic [31:0] key_ts;
    logic        key_none;
    logic [15:0] head_sn;
    logic [15:0] missing_sn;
    logic        key_seen;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [rfrt_pkg::SlotW-1:0] ring_slot(logic [15:0] sn);
        return sn[rfrt_pkg::SlotW-1:0];
    endfunction

    function automatic int scan_ring(logic [15:0] from, output logic [15:0] found);
        logic [31:0] ref_ts;
        logic [15:0] sn;
        ref_ts = ring_time[ring_slot(head_sn)];
        found = '0;
        for (int i = 0; i < rfrt_pkg::Depth; i++)
        begin
            sn = from + 16'(i);
            if (!ring_valid[ring_slot(sn)])
            begin
                found = sn;
                return ScanGap;
            end
            if (ring_time[ring_slot(sn)] != ref_ts)
            begin
                found = sn - 16'd1;
                return ScanEnd;
            end
            if (ring_flags[ring_slot(sn)][rfrt_pkg::FlMark])
            begin
                found = sn;
                return ScanEnd;
            end
        end
        return ScanOvf;
    endfunction

    task automatic predict_packet(packet_t p);
        logic        pli;
        logic        is_key;
        logic        do_scan;
        logic [15:0] from;
        logic [15:0] found;
        logic [15:0] len;
        logic [4:0]  fl;
        int          res;
        int          n;
        int          sc;
        int          ec;
        logic        key;
        pli = !key_seen;
        do_scan = 1'b0;
        from = '0;
        n = 0;
        if (p.nt == rfrt_pkg::NtStapa)
            is_key = (p.inner == rfrt_pkg::NtSps) || (p.inner == rfrt_pkg::NtPps);
        else
            is_key = (p.nt == rfrt_pkg::NtIdr) || (p.nt == rfrt_pkg::NtSps) ||
                     (p.nt == rfrt_pkg::NtPps);
        fl = '0;
        fl[rfrt_pkg::FlMark] = p.mark;
        if (p.nt == rfrt_pkg::NtFua)
        begin
            fl[rfrt_pkg::FlFua] = 1'b1;
            fl[rfrt_pkg::FlFus] = p.fus;
            fl[rfrt_pkg::FlFue] = p.fue;
        end
        fl[rfrt_pkg::FlKey] = is_key;
        if (is_key)
        begin
            key_seen = 1'b1;
            if (key_none || key_ts != p.ts)
            begin
                key_none = 1'b0;
                key_ts = p.ts;
                head_sn = p.sn;
                missing_sn = p.sn + 16'd1;
                for (int i = 0; i < rfrt_pkg::Depth; i++)
                    ring_valid[i] = 1'b0;
            end
        end
        ring_valid[ring_slot(p.sn)] = 1'b1;
        ring_time[ring_slot(p.sn)] = p.ts;
        ring_flags[ring_slot(p.sn)] = fl;
        len = p.sn - head_sn;
        if (is_key && len[15])
        begin
            head_sn = p.sn;
            from = p.sn;
            do_scan = 1'b1;
        end
        else if (missing_sn == p.sn)
        begin
            from = missing_sn;
            do_scan = 1'b1;
        end
        if (!do_scan)
        begin
            expected_reports.push_back('{rfrt_pkg::KIND_DONE, 16'd0, 16'd0, 1'b0, pli, 1'b1});
            return;
        end
        res = scan_ring(from, found);
        while (res == ScanEnd)
        begin
            len = found - head_sn + 16'd1;
            if (len == 0 || len > rfrt_pkg::Depth)
            begin
                res = ScanOvf;
                break;
            end
            sc = 0;
            ec = 0;
            for (int i = 0; i < len; i++)
            begin
                fl = ring_flags[ring_slot(head_sn + 16'(i))];
                if (fl[rfrt_pkg::FlFua])
                begin
                    sc += fl[rfrt_pkg::FlFus];
                    ec += fl[rfrt_pkg::FlFue];
                end
            end
            if (sc != ec || n >= rfrt_pkg::MaxFrames)
                break;
            key = ring_flags[ring_slot(head_sn)][rfrt_pkg::FlKey];
            if (key)
                key_none = 1'b1;
            for (int i = 0; i < len; i++)
                ring_valid[ring_slot(head_sn + 16'(i))] = 1'b0;
            expected_reports.push_back('{rfrt_pkg::KIND_FRAME, head_sn, found, key, pli, 1'b0});
            n++;
            head_sn = found + 16'd1;
            res = scan_ring(head_sn, found);
        end
        if (res == ScanGap)
            missing_sn = found;
        expected_reports.push_back('{res == ScanOvf ? rfrt_pkg::KIND_OVERFLOW :
                                     rfrt_pkg::KIND_DONE,
                                     16'd0, 16'd0, 1'b0, pli, 1'b1});
    endtask

    function automatic packet_t make_packet(logic [15:0] sn, logic [31:0] ts, logic mark,
                                            logic [4:0] nt, logic [4:0] inner,
                                            logic fus, logic fue);
        return '{sn, ts, mark, nt, inner, fus, fue};
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            seq_num <= '0;
            rtp_time <= '0;
            marker <= 1'b0;
            nal_type <= '0;
            inner_nal_type <= '0;
            fu_start <= 1'b0;
            fu_end <= 1'b0;
            key_none = 1'b1;
            key_ts = '0;
            head_sn = '0;
            missing_sn = '0;
            key_seen = 1'b0;
            for (int i = 0; i < rfrt_pkg::Depth; i++)
            begin
                ring_valid[i] = 1'b0;
                ring_time[i] = '0;
                ring_flags[i] = '0;
            end
        end
        else
        begin
            if (start && !busy)
            begin
                predict_packet(packet_queue.pop_front());
            end
            if (!(start && busy))
            begin
                if (packet_queue.size() > 0 && !hold_sender
                    && $urandom_range(99) >= send_idle_pct)
                begin
                    start <= 1'b1;
                    seq_num <= packet_queue[0].sn;
                    rtp_time <= packet_queue[0].ts;
                    marker <= packet_queue[0].mark;
                    nal_type <= packet_queue[0].nt;
                    inner_nal_type <= packet_queue[0].inner;
                    fu_start <= packet_queue[0].fus;
                    fu_end <= packet_queue[0].fue;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && valid)
        begin
            if (expected_reports.size() == 0)
            begin
                $display("%0t: unexpected result kind=%0d start=%0d end=%0d", $time,
                         kind, frame_start_sn, frame_end_sn);
                errors++;
            end
            else
            begin
                report_t e;
                e = expected_reports.pop_front();
                if ({kind, frame_start_sn, frame_end_sn, key_frame, pli_request, last} != e)
                begin
                    $display("%0t: expected kind=%0d start=%0d end=%0d key=%0b pli=%0b last=%0b",
                             $time, e.kind, e.first_sn, e.last_sn, e.key, e.pli, e.fin);
                    $display("%0t:   actual kind=%0d start=%0d end=%0d key=%0b pli=%0b last=%0b",
                             $time, kind, frame_start_sn, frame_end_sn, key_frame,
                             pli_request, last);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 2000000)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic add_frame(inout logic [15:0] sn, input logic [31:0] ts,
                             input logic key_first, input int pkts);
        logic [4:0] nt;
        logic fu;
        fu = $urandom_range(1);
        for (int i = 0; i < pkts; i++)
        begin
            if (i == 0 && key_first)
                nt = rfrt_pkg::NtIdr;
            else if (fu)
                nt = rfrt_pkg::NtFua;
            else
                nt = 5'($urandom_range(1, 4));
            packet_queue.push_back(make_packet(sn, ts, i == pkts - 1, nt,
                5'($urandom), fu && i == 0 || fu && key_first && i == 1,
                fu && i == pkts - 1));
            sn++;
        end
    endtask

    task automatic wait_drained();
        while (packet_queue.size() > 0 || start || busy || expected_reports.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [15:0] sn;
        logic [31:0] ts;
        packet_t     p;
        int          pkts;
        hold_sender = 1'b0;
        send_idle_pct = 25;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: non-key before key writes entry 0 then a key restarts head.
        packet_queue.push_back(make_packet(16'd0, 32'd0, 1'b1, 5'd1, 5'd0, 1'b0, 1'b0));
        packet_queue.push_back(make_packet(16'd100, 32'hFFFF_FFFF, 1'b0, rfrt_pkg::NtSps,
                                           5'd0, 1'b0, 1'b0));
        packet_queue.push_back(make_packet(16'd101, 32'hFFFF_FFFF, 1'b0, rfrt_pkg::NtPps,
                                           5'd0, 1'b0, 1'b0));
        packet_queue.push_back(make_packet(16'd102, 32'hFFFF_FFFF, 1'b0, rfrt_pkg::NtFua,
                                           5'd0, 1'b1, 1'b0));
        packet_queue.push_back(make_packet(16'd104, 32'hFFFF_FFFF, 1'b1, rfrt_pkg::NtFua,
                                           5'd31, 1'b0, 1'b1));
        packet_queue.push_back(make_packet(16'd103, 32'hFFFF_FFFF, 1'b0, rfrt_pkg::NtFua,
                                           5'd0, 1'b1, 1'b1));
        // Key packet older than head moves head back.
        packet_queue.push_back(make_packet(16'd105, 32'd7, 1'b0, rfrt_pkg::NtStapa,
                                           rfrt_pkg::NtSps, 1'b0, 1'b0));
        packet_queue.push_back(make_packet(16'd103, 32'd7, 1'b1, rfrt_pkg::NtStapa,
                                           rfrt_pkg::NtPps, 1'b0, 1'b0));
        // Unbalanced FU-A frame stays incomplete.
        packet_queue.push_back(make_packet(16'd200, 32'd9, 1'b0, rfrt_pkg::NtIdr,
                                           5'd0, 1'b0, 1'b0));
        packet_queue.push_back(make_packet(16'd201, 32'd9, 1'b1, rfrt_pkg::NtFua,
                                           5'd0, 1'b1, 1'b0));
        // Wrap of the sequence number and a long run that overflows.
        sn = 16'hFFF0;
        packet_queue.push_back(make_packet(sn, 32'd11, 1'b0, rfrt_pkg::NtIdr, 5'd0,
                                           1'b0, 1'b0));
        for (int i = 1; i <= rfrt_pkg::Depth; i++)
            packet_queue.push_back(make_packet(sn + 16'(i), 32'd11, 1'b0, 5'd1, 5'd0,
                                               1'b0, 1'b0));
        wait_drained();

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 25 : (phase == 1) ? 52 : 0;
            sn = 16'($urandom);
            ts = $urandom;
            for (int f = 0; f < 25; f++)
            begin
                pkts = ($urandom_range(9) == 0) ? $urandom_range(20, 34) : $urandom_range(1, 4);
                if (f % 12 == 0 || $urandom_range(19) == 0)
                begin
                    ts = $urandom;
                    add_frame(sn, ts, 1'b1, pkts);
                end
                else
                begin
                    ts = ts + 32'd3000;
                    add_frame(sn, ts, 1'b0, pkts);
                end
                // Occasional reordering and loss in the recent packets.
                if ($urandom_range(4) == 0 && packet_queue.size() > 2)
                begin
                    p = packet_queue[packet_queue.size() - 1];
                    packet_queue[packet_queue.size() - 1] = packet_queue[packet_queue.size() - 2];
                    packet_queue[packet_queue.size() - 2] = p;
                end
                if ($urandom_range(14) == 0)
                    void'(packet_queue.pop_back());
                if ($urandom_range(9) == 0)
                    packet_queue.push_back(make_packet(16'($urandom), $urandom, 1'($urandom),
                        5'($urandom), 5'($urandom), 1'($urandom), 1'($urandom)));
            end
            if (phase == 0)
            begin
                while (packet_queue.size() > 60)
                    @(posedge clk);
                hold_sender = 1'b1;
                while (start || busy || expected_reports.size() > 0)
                    @(posedge clk);
                hold_sender = 1'b0;
            end
            wait_drained();
        end

        repeat (400) @(posedge clk);
        if (errors == 0 && expected_reports.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
